@@ hw/rtl/csa_pkg.sv @@
// Shared types and constants for the contiguous slot allocator.
`timescale 1ns / 1ps
`default_nettype none

package csa_pkg;

  localparam int unsigned CfgW   = 9;
  localparam int unsigned SlotW  = 8;
  localparam int unsigned CountW = 9;
  localparam int unsigned StatW  = 2;

  localparam logic ACT_ACQUIRE = 1'b0;
  localparam logic ACT_RELEASE = 1'b1;

  typedef enum logic [StatW-1:0] {
    ST_OK    = 2'd0,
    ST_NONE  = 2'd1,
    ST_FEW   = 2'd2,
    ST_NORUN = 2'd3
  } status_e;

  // Pool size as used: zero acts as one, anything above the pool acts as the pool.
  function automatic logic [CfgW-1:0] eff_size(logic [CfgW-1:0] v, int unsigned max_slots);
    logic [CfgW-1:0] r;
    if (v == '0) begin
      r = CfgW'(1);
    end else if (32'(v) > max_slots) begin
      r = CfgW'(max_slots);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/contiguous_slot_allocator.sv @@
// Top level of the first-fit contiguous slot allocator.
`timescale 1ns / 1ps
`default_nettype none

// The free map is a circular shift register of POOL_SLOTS bits that rotates one slot
// per cycle past a single read/modify point during a turn. An acquire request takes
// two full turns of the map (first-fit search, then marking), or only the search turn
// when no run fits; a release takes one turn; a zero count, or an acquire larger
// than the free total, is answered without a turn. One request is worked on at a
// time; a finished result sits in an output register so the next request can start
// while it waits. Writing the pool size register frees every slot of the new pool
// and must happen only while the block is idle.
module contiguous_slot_allocator
  import csa_pkg::*;
#(
  parameter int unsigned POOL_SLOTS = 256
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  cfg_we_i,
  input  wire [CfgW-1:0]       cfg_wdata_i,
  input  wire                  in_valid_i,
  output logic                 in_stall_o,
  input  wire                  action_i,
  input  wire [SlotW-1:0]      first_slot_i,
  input  wire [CountW-1:0]     slot_count_i,
  output logic                 out_valid_o,
  input  wire                  out_stall_i,
  output logic [StatW-1:0]     status_o,
  output logic [SlotW-1:0]     grant_slot_o,
  output logic [CfgW-1:0]      free_left_o
);

  localparam int unsigned IW = $clog2(POOL_SLOTS);
  localparam int unsigned CW = (IW + 1 > 10) ? IW + 1 : 10;
  localparam logic [IW-1:0] LastIdx = IW'(POOL_SLOTS - 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_PASS = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]            state_q;
  logic [POOL_SLOTS-1:0] map_q;
  logic [CfgW-1:0]       pool_size_q;
  logic [CfgW-1:0]       free_total_q;
  logic [IW-1:0]         idx_q;
  logic [CW-1:0]         run_q;
  logic                  found_q;
  logic [CW-1:0]         start_q;
  logic [CW-1:0]         end_q;
  logic [CountW-1:0]     count_q;
  logic                  op_q;
  status_e               res_status_q;
  logic                  out_valid_q;
  status_e               out_status_q;
  logic [SlotW-1:0]      out_start_q;
  logic [CfgW-1:0]       out_free_q;

  logic [CfgW-1:0]       lim;
  logic [CfgW-1:0]       lim_wr;
  logic                  cur_bit;
  logic                  below_lim;
  logic                  slot_free;
  logic [CW-1:0]         run_inc;
  logic                  found_now;
  logic [CW-1:0]         start_now;
  logic [CW-1:0]         start_sel;
  logic                  in_rng;
  logic                  new_bit;
  logic                  inc_free;
  logic                  last_idx;
  logic                  out_free;
  logic                  res_load;

  assign lim       = eff_size(pool_size_q, POOL_SLOTS);
  assign lim_wr    = eff_size(cfg_wdata_i, POOL_SLOTS);
  assign cur_bit   = map_q[0];
  assign below_lim = CW'(idx_q) < CW'(lim);
  assign slot_free = cur_bit && below_lim;
  assign run_inc   = run_q + CW'(1);
  assign found_now = slot_free && !found_q && (run_inc >= CW'(count_q));
  assign start_now = CW'(idx_q) + CW'(1) - CW'(count_q);
  assign start_sel = found_now ? start_now : start_q;
  assign in_rng    = (CW'(idx_q) >= start_q) && (CW'(idx_q) < end_q);
  assign last_idx  = idx_q == LastIdx;
  assign out_free  = !out_valid_q || !out_stall_i;
  assign res_load  = !cfg_we_i && state_q == S_DONE && out_free;

  always_comb begin
    new_bit  = cur_bit;
    inc_free = 1'b0;
    if (op_q == ACT_ACQUIRE) begin
      if (in_rng) begin
        new_bit = 1'b0;
      end
    end else if (in_rng && below_lim) begin
      new_bit  = 1'b1;
      inc_free = !cur_bit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      pool_size_q  <= CfgW'(256);
      free_total_q <= eff_size(CfgW'(256), POOL_SLOTS);
      for (int i = 0; i < POOL_SLOTS; i++) begin
        map_q[i] <= CW'(i) < CW'(eff_size(CfgW'(256), POOL_SLOTS));
      end
      idx_q        <= '0;
      run_q        <= '0;
      found_q      <= 1'b0;
      start_q      <= '0;
      end_q        <= '0;
      count_q      <= '0;
      op_q         <= ACT_ACQUIRE;
      res_status_q <= ST_OK;
      out_valid_q  <= 1'b0;
    end else begin
      if (res_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        pool_size_q  <= cfg_wdata_i;
        free_total_q <= lim_wr;
        for (int i = 0; i < POOL_SLOTS; i++) begin
          map_q[i] <= CW'(i) < CW'(lim_wr);
        end
      end else begin
        case (state_q)
          S_IDLE: begin
            if (in_valid_i) begin
              count_q <= slot_count_i;
              op_q    <= action_i;
              idx_q   <= '0;
              run_q   <= '0;
              found_q <= 1'b0;
              start_q <= CW'(first_slot_i);
              end_q   <= CW'(first_slot_i) + CW'(slot_count_i);
              if (slot_count_i == '0) begin
                res_status_q <= ST_NONE;
                state_q      <= S_DONE;
              end else if (action_i == ACT_RELEASE) begin
                res_status_q <= ST_OK;
                state_q      <= S_PASS;
              end else if (slot_count_i > free_total_q) begin
                res_status_q <= ST_FEW;
                state_q      <= S_DONE;
              end else begin
                res_status_q <= ST_OK;
                state_q      <= S_SCAN;
              end
            end
          end
          S_SCAN: begin
            map_q <= {cur_bit, map_q[POOL_SLOTS-1:1]};
            idx_q <= last_idx ? '0 : idx_q + IW'(1);
            run_q <= slot_free ? run_inc : '0;
            if (found_now) begin
              found_q <= 1'b1;
              start_q <= start_now;
            end
            if (last_idx) begin
              if (found_q || found_now) begin
                end_q        <= start_sel + CW'(count_q);
                free_total_q <= free_total_q - count_q;
                state_q      <= S_PASS;
              end else begin
                res_status_q <= ST_NORUN;
                state_q      <= S_DONE;
              end
            end
          end
          S_PASS: begin
            map_q <= {new_bit, map_q[POOL_SLOTS-1:1]};
            idx_q <= last_idx ? '0 : idx_q + IW'(1);
            if (inc_free) begin
              free_total_q <= free_total_q + CfgW'(1);
            end
            if (last_idx) begin
              state_q <= S_DONE;
            end
          end
          S_DONE: begin
            if (out_free) begin
              state_q <= S_IDLE;
            end
          end
          default: state_q <= S_IDLE;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      out_status_q <= res_status_q;
      out_start_q  <= (res_status_q == ST_OK && op_q == ACT_ACQUIRE) ?
                      start_q[SlotW-1:0] : '0;
      out_free_q   <= free_total_q;
    end
  end

  assign in_stall_o   = (state_q != S_IDLE) || cfg_we_i;
  assign out_valid_o  = out_valid_q;
  assign status_o     = out_status_q;
  assign grant_slot_o = out_start_q;
  assign free_left_o  = out_free_q;

  a_free_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_total_q <= lim)
    else $error("free total exceeds pool size");

  a_fail_no_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> grant_slot_o == '0)
    else $error("failed request reports a start slot");

  a_zero_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !cfg_we_i && slot_count_i == '0 |=>
    state_q == S_DONE && res_status_q == ST_NONE)
    else $error("zero count request not answered at once");

  a_scan_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_PASS && op_q == ACT_ACQUIRE |-> found_q)
    else $error("marking pass without a found run");

endmodule

`default_nettype wire

@@ dv/tb_contiguous_slot_allocator.sv @@
// Self-checking testbench for the contiguous slot allocator: directed table, then random phases.
`timescale 1ns / 1ps

module tb_contiguous_slot_allocator;
  import csa_pkg::*;

  localparam int unsigned PoolSlots     = 256;
  localparam int unsigned NumDirected   = 24;
  localparam int unsigned NumFixed      = 8;
  localparam int unsigned NumPhases     = 10;
  localparam int unsigned ItemsPerPhase = 72;

  typedef struct packed {
    status_e           status;
    logic [SlotW-1:0]  grant_slot;
    logic [CfgW-1:0]   free_left;
  } alloc_resp_t;

  typedef struct packed {
    logic              action;
    logic [SlotW-1:0]  first_slot;
    logic [CountW-1:0] slot_count;
    logic              has_resp;
    alloc_resp_t       resp;
  } dir_row_t;

  typedef struct packed {
    logic [SlotW-1:0]  start;
    logic [CountW-1:0] count;
  } run_t;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [CfgW-1:0]   cfg_wdata_i;
  logic              in_valid_i;
  logic              in_stall_o;
  logic              action_i;
  logic [SlotW-1:0]  first_slot_i;
  logic [CountW-1:0] slot_count_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic [StatW-1:0]  status_o;
  logic [SlotW-1:0]  grant_slot_o;
  logic [CfgW-1:0]   free_left_o;

  logic [PoolSlots-1:0] free_map;
  int unsigned          free_total;
  int unsigned          pool_lim;
  alloc_resp_t          alloc_resp_q[$];
  run_t                 granted_q[$];
  int unsigned          fail_cnt = 0;
  bit                   quiet = 1'b0;

  // Full pool after reset, then fragmentation, first fit and double release.
  dir_row_t dir_rows [NumDirected] = '{
    '{ACT_ACQUIRE, 8'd0,   9'd0,   1'b1, '{ST_NONE,  8'd0,   9'd256}},
    '{ACT_RELEASE, 8'd255, 9'd0,   1'b1, '{ST_NONE,  8'd0,   9'd256}},
    '{ACT_ACQUIRE, 8'd0,   9'd257, 1'b1, '{ST_FEW,   8'd0,   9'd256}},
    '{ACT_ACQUIRE, 8'd255, 9'd511, 1'b1, '{ST_FEW,   8'd0,   9'd256}},
    '{ACT_ACQUIRE, 8'd0,   9'd256, 1'b1, '{ST_OK,    8'd0,   9'd0}},
    '{ACT_ACQUIRE, 8'd0,   9'd1,   1'b1, '{ST_FEW,   8'd0,   9'd0}},
    '{ACT_RELEASE, 8'd255, 9'd511, 1'b1, '{ST_OK,    8'd0,   9'd1}},
    '{ACT_RELEASE, 8'd10,  9'd1,   1'b1, '{ST_OK,    8'd0,   9'd2}},
    '{ACT_RELEASE, 8'd200, 9'd1,   1'b1, '{ST_OK,    8'd0,   9'd3}},
    '{ACT_ACQUIRE, 8'd0,   9'd2,   1'b1, '{ST_NORUN, 8'd0,   9'd3}},
    '{ACT_ACQUIRE, 8'd0,   9'd3,   1'b1, '{ST_NORUN, 8'd0,   9'd3}},
    '{ACT_ACQUIRE, 8'd0,   9'd1,   1'b1, '{ST_OK,    8'd10,  9'd2}},
    '{ACT_RELEASE, 8'd199, 9'd2,   1'b1, '{ST_OK,    8'd0,   9'd3}},
    '{ACT_ACQUIRE, 8'd0,   9'd2,   1'b1, '{ST_OK,    8'd199, 9'd1}},
    '{ACT_ACQUIRE, 8'd0,   9'd1,   1'b1, '{ST_OK,    8'd255, 9'd0}},
    '{ACT_RELEASE, 8'd0,   9'd256, 1'b1, '{ST_OK,    8'd0,   9'd256}},
    '{ACT_RELEASE, 8'd0,   9'd256, 1'b1, '{ST_OK,    8'd0,   9'd256}},
    '{ACT_ACQUIRE, 8'd0,   9'd100, 1'b1, '{ST_OK,    8'd0,   9'd156}},
    '{ACT_ACQUIRE, 8'd0,   9'd156, 1'b1, '{ST_OK,    8'd100, 9'd0}},
    '{ACT_RELEASE, 8'd128, 9'd127, 1'b1, '{ST_OK,    8'd0,   9'd127}},
    '{ACT_ACQUIRE, 8'd0,   9'd127, 1'b0, '{ST_OK,    8'd0,   9'd0}},
    '{ACT_RELEASE, 8'd250, 9'd20,  1'b0, '{ST_OK,    8'd0,   9'd0}},
    '{ACT_ACQUIRE, 8'd255, 9'd5,   1'b0, '{ST_OK,    8'd0,   9'd0}},
    '{ACT_RELEASE, 8'd0,   9'd256, 1'b0, '{ST_OK,    8'd0,   9'd0}}
  };

  logic [CfgW-1:0] fixed_sizes [NumFixed] = '{
    9'd1, 9'd0, 9'd2, 9'd511, 9'd300, 9'd37, 9'd255, 9'd256
  };

  contiguous_slot_allocator #(
    .POOL_SLOTS(PoolSlots)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .action_i    (action_i),
    .first_slot_i(first_slot_i),
    .slot_count_i(slot_count_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .grant_slot_o(grant_slot_o),
    .free_left_o (free_left_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void pool_init(logic [CfgW-1:0] size);
    pool_lim = (size == '0) ? 1 : ((size > PoolSlots) ? PoolSlots : size);
    for (int i = 0; i < PoolSlots; i++) begin
      free_map[i] = (i < pool_lim);
    end
    free_total = pool_lim;
    granted_q.delete();
  endfunction

  function automatic alloc_resp_t alloc_predict(logic act, logic [SlotW-1:0] first,
                                                logic [CountW-1:0] cnt);
    alloc_resp_t r;
    run_t        g;
    int unsigned run_len;
    int unsigned start;
    bit          found;
    run_len  = 0;
    start    = 0;
    found    = 1'b0;
    r.status = ST_OK;
    if (cnt == '0) begin
      r.status = ST_NONE;
    end else if (act == ACT_ACQUIRE) begin
      if (cnt > free_total) begin
        r.status = ST_FEW;
      end else begin
        for (int i = 0; i < pool_lim && !found; i++) begin
          if (free_map[i]) begin
            run_len++;
            if (run_len >= cnt) begin
              start = i + 1 - cnt;
              found = 1'b1;
            end
          end else begin
            run_len = 0;
          end
        end
        if (!found) begin
          r.status = ST_NORUN;
          start    = 0;
        end else begin
          for (int i = start; i < start + cnt; i++) begin
            free_map[i] = 1'b0;
          end
          free_total -= cnt;
          g.start = SlotW'(start);
          g.count = cnt;
          granted_q = {granted_q, g};
        end
      end
    end else begin
      for (int i = first; i < first + cnt; i++) begin
        if (i < pool_lim && !free_map[i]) begin
          free_map[i] = 1'b1;
          free_total++;
        end
      end
    end
    r.grant_slot = SlotW'(start);
    r.free_left  = CfgW'(free_total);
    return r;
  endfunction

  task automatic send_request(logic act, logic [SlotW-1:0] first, logic [CountW-1:0] cnt,
                              logic has_resp, alloc_resp_t fixed);
    alloc_resp_t pred;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    pred = alloc_predict(act, first, cnt);
    if (has_resp) begin
      pred = fixed;
    end
    alloc_resp_q = {alloc_resp_q, pred};
    in_valid_i   <= 1'b1;
    action_i     <= act;
    first_slot_i <= first;
    slot_count_i <= cnt;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic write_pool_size(logic [CfgW-1:0] size);
    in_valid_i <= 1'b0;
    while (alloc_resp_q.size() != 0) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= size;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    pool_init(size);
  endtask

  // Mostly acquires and releases of granted runs; the rest is noise.
  task automatic random_request();
    int unsigned      pick;
    int unsigned      idx;
    int unsigned      hi;
    run_t             g;
    logic [SlotW-1:0] junk;
    logic [SlotW-1:0] first;
    pick  = $urandom_range(0, 99);
    junk  = SlotW'($urandom);
    hi    = (pool_lim >= 8) ? pool_lim / 4 : 2;
    first = $urandom_range(0, 1) ? SlotW'($urandom_range(0, pool_lim - 1)) : SlotW'($urandom);
    if (pick < 45) begin
      send_request(ACT_ACQUIRE, junk,
                   CountW'($urandom_range(1, ($urandom_range(0, 9) == 0) ? pool_lim : hi)),
                   1'b0, '0);
    end else if (pick < 75 && granted_q.size() != 0) begin
      idx = $urandom_range(0, granted_q.size() - 1);
      g   = granted_q[idx];
      granted_q.delete(idx);
      send_request(ACT_RELEASE, g.start, g.count, 1'b0, '0);
    end else if (pick < 87) begin
      send_request(ACT_RELEASE, first,
                   CountW'($urandom_range(0, ($urandom_range(0, 3) == 0) ? 511 : 16)),
                   1'b0, '0);
    end else if (pick < 92) begin
      send_request(1'($urandom_range(0, 1)), junk, '0, 1'b0, '0);
    end else begin
      send_request(ACT_ACQUIRE, junk, CountW'($urandom_range(0, 511)), 1'b0, '0);
    end
  endtask

  task automatic check_resp();
    alloc_resp_t exp_r;
    if (alloc_resp_q.size() == 0) begin
      $error("unexpected response: status %0d grant_slot %0d free_left %0d",
             status_o, grant_slot_o, free_left_o);
      fail_cnt++;
    end else begin
      exp_r = alloc_resp_q.pop_front();
      if (status_o !== exp_r.status) begin
        $error("status: expected %0d, actual %0d", exp_r.status, status_o);
        fail_cnt++;
      end
      if (grant_slot_o !== exp_r.grant_slot) begin
        $error("grant_slot: expected %0d, actual %0d", exp_r.grant_slot, grant_slot_o);
        fail_cnt++;
      end
      if (free_left_o !== exp_r.free_left) begin
        $error("free_left: expected %0d, actual %0d", exp_r.free_left, free_left_o);
        fail_cnt++;
      end
    end
  endtask

  initial begin
    int unsigned hold;
    hold        = 0;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o === 1'b1 && !out_stall_i) begin
        check_resp();
      end
      if (hold > 0) begin
        hold--;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        hold = $urandom_range(1, 17);
      end
      out_stall_i <= (hold > 0);
    end
  end

  initial begin
    logic [CfgW-1:0] size;
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_wdata_i  = '0;
    in_valid_i   = 1'b0;
    action_i     = ACT_ACQUIRE;
    first_slot_i = '0;
    slot_count_i = '0;
    pool_init(CfgW'(PoolSlots));
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (dir_rows[k]) begin
      send_request(dir_rows[k].action, dir_rows[k].first_slot, dir_rows[k].slot_count,
                   dir_rows[k].has_resp, dir_rows[k].resp);
    end
    for (int p = 0; p < NumPhases; p++) begin
      size = (p < NumFixed) ? fixed_sizes[p] : CfgW'($urandom_range(3, PoolSlots));
      if (p == NumPhases - 1) begin
        quiet = 1'b1;
      end
      write_pool_size(size);
      repeat (ItemsPerPhase) random_request();
    end
    in_valid_i <= 1'b0;
    while (alloc_resp_q.size() != 0) @(posedge clk_i);
    repeat (2 * PoolSlots + 16) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
